[design/sfr_pkg.sv]
// Shared types and constants for the stream find-and-replace block.
// Used by sfr_cfg, sfr_cell and stream_find_replace; depends on nothing.
package sfr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int BYTE_W          = 8;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int LEN_W           = 4;
    localparam int RIDX_W          = $clog2(MAX_REPLACEMENT);

    localparam logic [CFG_IDX_W-1:0] REG_PAT_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REP_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LEN   = 2'd3;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pat;
        logic [LEN_W-1:0]      plen;
        logic [CFG_DATA_W-1:0] rep;
        logic [LEN_W-1:0]      rlen;
    } t_cfg;

    typedef struct packed {
        logic take_in;
        logic shift;
        logic used;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPL,
        ST_SHIFT,
        ST_MARK
    } t_state;

endpackage

[design/sfr_cfg.sv]
// Configuration registers of the find-and-replace block with length saturation.
// Depends on sfr_pkg.
module sfr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_data,
    input  logic                           i_window_empty,
    output sfr_pkg::t_cfg                  o_cfg
);
    import sfr_pkg::*;

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic [LEN_W-1:0] v4;

    always_comb begin
        v4    = i_data[LEN_W-1:0];
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                REG_PAT_BYTES: n_cfg.pat = i_data;
                REG_PAT_LEN: begin
                    if (i_window_empty) begin
                        if (v4 == '0)
                            n_cfg.plen = LEN_W'(1);
                        else if (v4 > LEN_W'(MAX_PATTERN))
                            n_cfg.plen = LEN_W'(MAX_PATTERN);
                        else
                            n_cfg.plen = v4;
                    end
                end
                REG_REP_BYTES: n_cfg.rep = i_data;
                REG_REP_LEN: begin
                    if (v4 > LEN_W'(MAX_REPLACEMENT))
                        n_cfg.rlen = LEN_W'(MAX_REPLACEMENT);
                    else
                        n_cfg.rlen = v4;
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat  <= '0;
            r_cfg.plen <= LEN_W'(1);
            r_cfg.rep  <= '0;
            r_cfg.rlen <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/sfr_cell.sv]
// One window cell: holds a byte, shifts toward cell zero, compares to its pattern byte.
// Depends on sfr_pkg.
module sfr_cell (
    input  logic                       i_clk,
    input  sfr_pkg::t_cell_ctl         i_ctl,
    input  logic [sfr_pkg::BYTE_W-1:0] i_in_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_next_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] i_pat_byte,
    input  logic                       i_match,
    output logic [sfr_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_match
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] cand;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_in) begin
            r_byte <= i_in_byte;
        end else if (i_ctl.shift) begin
            r_byte <= i_next_byte;
        end
    end

    assign cand    = i_ctl.take_in ? i_in_byte : r_byte;
    assign o_match = i_match & (~i_ctl.used | (cand == i_pat_byte));
    assign o_byte  = r_byte;

endmodule

[design/stream_find_replace.sv]
// Stream find-and-replace: lookahead window of cells, emit sequencer, output register.
// Results of an item pass through the emit sequencer's state register and then the output register.
// New items are taken only while the emit sequencer is idle, not while it emits results or waits on the output.
// Reset: synchronous active-low; window empty, flag cleared, config registers to defaults, output valid cleared.
// Depends on sfr_pkg, sfr_cfg and sfr_cell.
module stream_find_replace (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]     i_in_byte,
    input  logic                           i_in_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [sfr_pkg::BYTE_W-1:0]     o_out_byte,
    output logic                           o_byte_valid,
    output logic                           o_out_last,
    output logic                           o_any_found,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfr_pkg::*;

    t_cfg              cfg;
    t_state            r_state;
    t_state            n_state;
    logic [LEN_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  n_cnt;
    logic              r_found;
    logic              r_last;
    logic [RIDX_W-1:0] r_ridx;

    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_bvalid;
    logic              r_o_last;
    logic              r_o_any;

    logic              accept;
    logic              slot;
    logic [LEN_W-1:0]  cnt_new;
    logic              full;
    logic              match;
    logic              rep_done;
    logic              emit;
    logic              shift;
    logic [BYTE_W-1:0] e_byte;
    logic              e_bvalid;
    logic              e_last;
    logic              end_stream;

    t_cell_ctl         cell_ctl [MAX_PATTERN];
    logic [BYTE_W-1:0] cell_byte [MAX_PATTERN+1];
    logic              mchain [MAX_PATTERN+1];

    sfr_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_we           (i_cfg_valid & o_cfg_ready),
        .i_index        (i_cfg_index),
        .i_data         (i_cfg_data),
        .i_window_empty (r_cnt == '0),
        .o_cfg          (cfg)
    );

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign accept      = i_valid & o_ready;
    assign slot        = ~r_o_valid | i_ready;
    assign cnt_new     = r_cnt + LEN_W'(1);
    assign full        = (cnt_new == cfg.plen);
    assign rep_done    = ((LEN_W'(r_ridx) + LEN_W'(1)) == cfg.rlen);

    assign mchain[0]              = 1'b1;
    assign cell_byte[MAX_PATTERN] = '0;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        always_comb begin
            cell_ctl[k].take_in = accept & (r_cnt == LEN_W'(k));
            cell_ctl[k].shift   = shift;
            cell_ctl[k].used    = (LEN_W'(k) < cfg.plen);
        end

        sfr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[k]),
            .i_in_byte   (i_in_byte),
            .i_next_byte (cell_byte[k+1]),
            .i_pat_byte  (cfg.pat[k*BYTE_W +: BYTE_W]),
            .i_match     (mchain[k]),
            .o_byte      (cell_byte[k]),
            .o_match     (mchain[k+1])
        );
    end

    assign match = mchain[MAX_PATTERN];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (full && match) begin
                        if (cfg.rlen != '0)
                            n_state = ST_REPL;
                        else if (i_in_last)
                            n_state = ST_MARK;
                        else
                            n_state = ST_IDLE;
                    end else if (full || i_in_last) begin
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_REPL: begin
                if (slot && rep_done)
                    n_state = ST_IDLE;
            end
            ST_SHIFT: begin
                if (slot && (!r_last || r_cnt == LEN_W'(1)))
                    n_state = ST_IDLE;
            end
            ST_MARK: begin
                if (slot)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        emit     = 1'b0;
        shift    = 1'b0;
        e_byte   = '0;
        e_bvalid = 1'b1;
        e_last   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                emit = 1'b0;
            end
            ST_REPL: begin
                emit   = slot;
                e_byte = cfg.rep[{r_ridx, 3'b000} +: BYTE_W];
                e_last = r_last & rep_done;
            end
            ST_SHIFT: begin
                emit   = slot;
                shift  = slot;
                e_byte = cell_byte[0];
                e_last = r_last & (r_cnt == LEN_W'(1));
            end
            ST_MARK: begin
                emit     = slot;
                e_bvalid = 1'b0;
                e_last   = 1'b1;
            end
            default: emit = 1'b0;
        endcase
    end

    assign end_stream = emit & e_last;

    always_comb begin
        n_cnt = r_cnt;
        if (accept)
            n_cnt = (full && match) ? '0 : cnt_new;
        else if (shift)
            n_cnt = r_cnt - LEN_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_last    <= 1'b0;
            r_ridx    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (accept && full && match)
                r_found <= 1'b1;
            else if (end_stream)
                r_found <= 1'b0;
            if (accept) begin
                r_last <= i_in_last;
                r_ridx <= '0;
            end else if (emit && r_state == ST_REPL) begin
                r_ridx <= r_ridx + RIDX_W'(1);
            end
            if (emit)
                r_o_valid <= 1'b1;
            else if (i_ready)
                r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_byte   <= e_byte;
            r_o_bvalid <= e_bvalid;
            r_o_last   <= e_last;
            r_o_any    <= e_last & r_found;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_byte   = r_o_byte;
    assign o_byte_valid = r_o_bvalid;
    assign o_out_last   = r_o_last;
    assign o_any_found  = r_o_any;

endmodule

[design/sfr_checker.sv]
// Port-level checks for stream_find_replace, attached by bind.
// Depends on the top level's port list only.
module sfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_out_last,
    input logic       o_any_found
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_out_last))
        else $error("output transfer changed while stalled");

    a_mark_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_out_last && (o_out_byte == 8'h00))
        else $error("bare end marker not on final result");

    a_found_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_any_found |-> o_out_last)
        else $error("found flag outside final result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);
